FILE: hw/rtl/velocity_command_slew_limiter_defines.svh
// Assertion macros for the velocity command slew limiter checker.
// Needs signals named i_clk and i_rst_n in the scope that uses them.
`ifndef VELOCITY_COMMAND_SLEW_LIMITER_DEFINES_SVH
`define VELOCITY_COMMAND_SLEW_LIMITER_DEFINES_SVH

// Property checked every clock, off while reset is low
`define VCSL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define VCSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/vcsl_pkg.sv
// Shared types, constants and helpers for the velocity command slew limiter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vcsl_pkg;

    // Field widths
    localparam int unsigned VEL_W  = 16;
    localparam int unsigned LIM_W  = 15;
    localparam int unsigned ACC_W  = 16;
    localparam int unsigned TIME_W = 16;
    localparam int unsigned STEP_W = 12;   // capped step fits 0..4095
    localparam int unsigned CHG_W  = 12;   // acc * step >> 16 stays below 4096
    localparam int unsigned PROD_W = ACC_W + STEP_W;
    localparam int unsigned NM_W   = VEL_W + 5;   // holds 20 * 32768
    localparam int unsigned CFG_AW = 3;
    localparam int unsigned CFG_DW = 16;

    // Step limits, 2^-16 s units
    localparam logic [TIME_W-1:0] STEP_MIN = 16'd66;
    localparam logic [TIME_W-1:0] STEP_MAX = 16'd6554;
    localparam logic [TIME_W-1:0] STEP_CAP = 16'd3277;

    // Motion thresholds
    localparam logic [VEL_W-1:0] MOVE_LIN = 16'd10;
    localparam logic [VEL_W-1:0] MOVE_ANG = 16'd5;

    // Configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        CFG_LIMIT_X   = 3'd0,
        CFG_LIMIT_Y   = 3'd1,
        CFG_LIMIT_YAW = 3'd2,
        CFG_ACCEL     = 3'd3,
        CFG_DECEL     = 3'd4,
        CFG_ANG_ACCEL = 3'd5,
        CFG_DEAD_ZONE = 3'd6
    } t_cfg_idx;

    // Input request
    typedef struct packed {
        logic signed [VEL_W-1:0] target_x;
        logic signed [VEL_W-1:0] target_y;
        logic signed [VEL_W-1:0] target_yaw;
        logic [TIME_W-1:0]       step_time;
        logic [TIME_W-1:0]       elapsed_time;
    } t_in_item;

    // Result
    typedef struct packed {
        logic signed [VEL_W-1:0] speed_x;
        logic signed [VEL_W-1:0] speed_y;
        logic signed [VEL_W-1:0] speed_yaw;
        logic                    was_clamped;
        logic                    was_slewed;
        logic                    is_moving;
        logic                    at_max;
    } t_out_item;

    // Pipeline load strobes and priming state
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic primed;
    } t_ctl;

    // Per-step velocity change allowances
    typedef struct packed {
        logic [CHG_W-1:0] rise_lin;
        logic [CHG_W-1:0] fall_lin;
        logic [CHG_W-1:0] ang;
    } t_chg;

    // What one lane hands to the merge stage
    typedef struct packed {
        logic signed [VEL_W-1:0] held;
        logic                    clamped;
        logic                    slewed;
    } t_lane_res;

    // Magnitude of a 16-bit signed value; -32768 gives 32768
    function automatic logic [VEL_W-1:0] f_mag(input logic signed [VEL_W-1:0] v);
        logic [VEL_W-1:0] neg;
        neg = VEL_W'(-v);
        return v[VEL_W-1] ? neg : VEL_W'(v);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/vcsl_step.sv
// Step time selection and change allowances (pipeline stage 1).
// Depends on vcsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vcsl_step (
    input  wire logic                          i_clk,
    input  wire vcsl_pkg::t_ctl                i_ctl,
    input  wire logic [vcsl_pkg::TIME_W-1:0]   i_step_time,
    input  wire logic [vcsl_pkg::TIME_W-1:0]   i_elapsed_time,
    input  wire logic [vcsl_pkg::ACC_W-1:0]    i_accel,
    input  wire logic [vcsl_pkg::ACC_W-1:0]    i_decel,
    input  wire logic [vcsl_pkg::ACC_W-1:0]    i_ang_accel,
    output vcsl_pkg::t_chg                     o_chg
);

    logic [vcsl_pkg::TIME_W-1:0] step_a;
    logic [vcsl_pkg::TIME_W-1:0] step_b;
    logic [vcsl_pkg::STEP_W-1:0] step_c;
    logic [vcsl_pkg::PROD_W-1:0] p_rise;
    logic [vcsl_pkg::PROD_W-1:0] p_fall;
    logic [vcsl_pkg::PROD_W-1:0] p_ang;
    vcsl_pkg::t_chg              r_chg;
    vcsl_pkg::t_chg              n_chg;

    // Clamp nominal step, take the larger of it and elapsed, then cap
    always_comb begin
        if (i_step_time < vcsl_pkg::STEP_MIN) begin
            step_a = vcsl_pkg::STEP_MIN;
        end else if (i_step_time > vcsl_pkg::STEP_MAX) begin
            step_a = vcsl_pkg::STEP_MAX;
        end else begin
            step_a = i_step_time;
        end
        step_b = (i_elapsed_time > step_a) ? i_elapsed_time : step_a;
        if (step_b > vcsl_pkg::STEP_CAP) begin
            step_c = vcsl_pkg::STEP_CAP[vcsl_pkg::STEP_W-1:0];
        end else begin
            step_c = step_b[vcsl_pkg::STEP_W-1:0];
        end
    end

    // acc * step in 2^-16 s, keep the integer part
    always_comb begin
        p_rise = vcsl_pkg::PROD_W'(i_accel) * vcsl_pkg::PROD_W'(step_c);
        p_fall = vcsl_pkg::PROD_W'(i_decel) * vcsl_pkg::PROD_W'(step_c);
        p_ang  = vcsl_pkg::PROD_W'(i_ang_accel) * vcsl_pkg::PROD_W'(step_c);
        n_chg.rise_lin = p_rise[vcsl_pkg::PROD_W-1:vcsl_pkg::ACC_W];
        n_chg.fall_lin = p_fall[vcsl_pkg::PROD_W-1:vcsl_pkg::ACC_W];
        n_chg.ang      = p_ang[vcsl_pkg::PROD_W-1:vcsl_pkg::ACC_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_chg <= n_chg;
        end
    end

    assign o_chg = r_chg;

endmodule

`default_nettype wire

FILE: hw/rtl/vcsl_lane.sv
// One axis lane: deadband and clamp (stage 1), slew toward target (stage 2).
// Depends on vcsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vcsl_lane (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire vcsl_pkg::t_ctl                     i_ctl,
    input  wire logic signed [vcsl_pkg::VEL_W-1:0]  i_target,
    input  wire logic [vcsl_pkg::LIM_W-1:0]         i_limit,
    input  wire logic [vcsl_pkg::LIM_W-1:0]         i_dead_zone,
    input  wire logic [vcsl_pkg::CHG_W-1:0]         i_chg_rise,
    input  wire logic [vcsl_pkg::CHG_W-1:0]         i_chg_fall,
    output vcsl_pkg::t_lane_res                     o_res
);

    logic signed [vcsl_pkg::VEL_W-1:0] v_db;
    logic signed [vcsl_pkg::VEL_W:0]   v_wide;
    logic signed [vcsl_pkg::VEL_W:0]   lim_pos;
    logic signed [vcsl_pkg::VEL_W:0]   lim_neg;
    logic signed [vcsl_pkg::VEL_W-1:0] n_tgt;
    logic                              n_clamp1;
    logic signed [vcsl_pkg::VEL_W-1:0] r_tgt;
    logic                              r_clamp1;

    logic signed [vcsl_pkg::VEL_W:0]   diff;
    logic [vcsl_pkg::VEL_W:0]          mag_diff;
    logic                              rise;
    logic [vcsl_pkg::CHG_W-1:0]        chg;
    logic signed [vcsl_pkg::VEL_W-1:0] chg_s;
    logic signed [vcsl_pkg::VEL_W-1:0] slewed_val;
    logic signed [vcsl_pkg::VEL_W-1:0] n_held;
    logic                              n_slew;
    logic signed [vcsl_pkg::VEL_W-1:0] r_held;
    logic                              r_clamp2;
    logic                              r_slew;

    // Stage 1: deadband, then clamp to +-limit
    always_comb begin
        v_db    = (vcsl_pkg::f_mag(i_target) < vcsl_pkg::VEL_W'(i_dead_zone)) ?
                  '0 : i_target;
        v_wide  = {v_db[vcsl_pkg::VEL_W-1], v_db};
        lim_pos = $signed({2'b00, i_limit});
        lim_neg = -lim_pos;
        if (v_wide > lim_pos) begin
            n_tgt = lim_pos[vcsl_pkg::VEL_W-1:0];
        end else if (v_wide < lim_neg) begin
            n_tgt = lim_neg[vcsl_pkg::VEL_W-1:0];
        end else begin
            n_tgt = v_db;
        end
        n_clamp1 = (n_tgt != v_db);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_tgt    <= n_tgt;
            r_clamp1 <= n_clamp1;
        end
    end

    // Stage 2: move held value toward target by at most the allowance
    always_comb begin
        diff     = {r_tgt[vcsl_pkg::VEL_W-1], r_tgt} - {r_held[vcsl_pkg::VEL_W-1], r_held};
        mag_diff = diff[vcsl_pkg::VEL_W] ? (vcsl_pkg::VEL_W+1)'(-diff) : diff;
        rise     = !diff[vcsl_pkg::VEL_W] && (diff != '0);
        chg      = rise ? i_chg_rise : i_chg_fall;
        chg_s    = $signed(vcsl_pkg::VEL_W'(chg));
        slewed_val = rise ? (r_held + chg_s) : (r_held - chg_s);
        if (!i_ctl.primed) begin
            // first command after reset passes through
            n_held = r_tgt;
        end else if (mag_diff <= (vcsl_pkg::VEL_W+1)'(chg)) begin
            n_held = r_tgt;
        end else begin
            n_held = slewed_val;
        end
        n_slew = i_ctl.primed && (n_held != r_tgt);
    end

    // Held velocity is the lane state and the stage 2 payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_ctl.ld2) begin
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_clamp2 <= r_clamp1;
            r_slew   <= n_slew;
        end
    end

    assign o_res.held    = r_held;
    assign o_res.clamped = r_clamp2;
    assign o_res.slewed  = r_slew;

endmodule

`default_nettype wire

FILE: hw/rtl/vcsl_merge.sv
// Merge stage: combines lane results into flags, holds the output register.
// Depends on vcsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vcsl_merge (
    input  wire logic                       i_clk,
    input  wire vcsl_pkg::t_ctl             i_ctl,
    input  wire vcsl_pkg::t_lane_res        i_res_x,
    input  wire vcsl_pkg::t_lane_res        i_res_y,
    input  wire vcsl_pkg::t_lane_res        i_res_yaw,
    input  wire logic [vcsl_pkg::LIM_W-1:0] i_limit_x,
    input  wire logic [vcsl_pkg::LIM_W-1:0] i_limit_y,
    input  wire logic [vcsl_pkg::LIM_W-1:0] i_limit_yaw,
    output vcsl_pkg::t_out_item             o_item
);

    logic [vcsl_pkg::VEL_W-1:0] mag_x;
    logic [vcsl_pkg::VEL_W-1:0] mag_y;
    logic [vcsl_pkg::VEL_W-1:0] mag_yaw;
    vcsl_pkg::t_out_item        n_item;
    vcsl_pkg::t_out_item        r_item;

    // 20*|v| >= 19*limit, i.e. within 95 percent of the limit
    function automatic logic f_near_max(input logic [vcsl_pkg::VEL_W-1:0] m,
                                        input logic [vcsl_pkg::LIM_W-1:0] lim);
        logic [vcsl_pkg::NM_W-1:0] lhs;
        logic [vcsl_pkg::NM_W-1:0] rhs;
        lhs = vcsl_pkg::NM_W'(m) * vcsl_pkg::NM_W'(20);
        rhs = vcsl_pkg::NM_W'(lim) * vcsl_pkg::NM_W'(19);
        return lhs >= rhs;
    endfunction

    always_comb begin
        mag_x   = vcsl_pkg::f_mag(i_res_x.held);
        mag_y   = vcsl_pkg::f_mag(i_res_y.held);
        mag_yaw = vcsl_pkg::f_mag(i_res_yaw.held);
        n_item.speed_x     = i_res_x.held;
        n_item.speed_y     = i_res_y.held;
        n_item.speed_yaw   = i_res_yaw.held;
        n_item.was_clamped = i_res_x.clamped | i_res_y.clamped | i_res_yaw.clamped;
        n_item.was_slewed  = i_res_x.slewed | i_res_y.slewed | i_res_yaw.slewed;
        n_item.is_moving   = (mag_x > vcsl_pkg::MOVE_LIN) || (mag_y > vcsl_pkg::MOVE_LIN) ||
                             (mag_yaw > vcsl_pkg::MOVE_ANG);
        n_item.at_max      = f_near_max(mag_x, i_limit_x) || f_near_max(mag_y, i_limit_y) ||
                             f_near_max(mag_yaw, i_limit_yaw);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

`default_nettype wire

FILE: hw/rtl/velocity_command_slew_limiter.sv
// Throughput: one request per cycle while the output is not stalled; each stage
// advances when the next is free, so input is taken while a finished result
// waits. The rate is set by the held-velocity loop in stage 2 (subtract, compare,
// add per axis). Synchronous active-low reset clears stage valids, configuration,
// held velocities and the primed flag.
// Depends on vcsl_pkg, vcsl_step, vcsl_lane, vcsl_merge.
`timescale 1ns / 1ps
`default_nettype none

module velocity_command_slew_limiter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [vcsl_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  wire logic [vcsl_pkg::CFG_DW-1:0]   i_cfg_wdata,
    // input requests
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire vcsl_pkg::t_in_item            i_in_data,
    // results
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output vcsl_pkg::t_out_item                o_out_data
);

    logic [vcsl_pkg::LIM_W-1:0] r_limit_x;
    logic [vcsl_pkg::LIM_W-1:0] r_limit_y;
    logic [vcsl_pkg::LIM_W-1:0] r_limit_yaw;
    logic [vcsl_pkg::ACC_W-1:0] r_accel;
    logic [vcsl_pkg::ACC_W-1:0] r_decel;
    logic [vcsl_pkg::ACC_W-1:0] r_ang_accel;
    logic [vcsl_pkg::LIM_W-1:0] r_dead_zone;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_primed;
    logic n_v1;
    logic n_v2;
    logic n_v3;
    logic rdy1;
    logic rdy2;
    logic rdy3;

    vcsl_pkg::t_ctl      ctl;
    vcsl_pkg::t_chg      chg;
    vcsl_pkg::t_lane_res res_x;
    vcsl_pkg::t_lane_res res_y;
    vcsl_pkg::t_lane_res res_yaw;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_x   <= '0;
            r_limit_y   <= '0;
            r_limit_yaw <= '0;
            r_accel     <= '0;
            r_decel     <= '0;
            r_ang_accel <= '0;
            r_dead_zone <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                vcsl_pkg::CFG_LIMIT_X:   r_limit_x   <= i_cfg_wdata[vcsl_pkg::LIM_W-1:0];
                vcsl_pkg::CFG_LIMIT_Y:   r_limit_y   <= i_cfg_wdata[vcsl_pkg::LIM_W-1:0];
                vcsl_pkg::CFG_LIMIT_YAW: r_limit_yaw <= i_cfg_wdata[vcsl_pkg::LIM_W-1:0];
                vcsl_pkg::CFG_ACCEL:     r_accel     <= i_cfg_wdata;
                vcsl_pkg::CFG_DECEL:     r_decel     <= i_cfg_wdata;
                vcsl_pkg::CFG_ANG_ACCEL: r_ang_accel <= i_cfg_wdata;
                vcsl_pkg::CFG_DEAD_ZONE: r_dead_zone <= i_cfg_wdata[vcsl_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow: a stage loads when its input is valid and it is free
    always_comb begin
        rdy3       = !r_v3 || !i_out_stall;
        rdy2       = !r_v2 || rdy3;
        rdy1       = !r_v1 || rdy2;
        ctl.ld1    = i_in_valid && rdy1;
        ctl.ld2    = r_v1 && rdy2;
        ctl.ld3    = r_v2 && rdy3;
        ctl.primed = r_primed;
        n_v1       = ctl.ld1 || (r_v1 && !ctl.ld2);
        n_v2       = ctl.ld2 || (r_v2 && !ctl.ld3);
        n_v3       = ctl.ld3 || (r_v3 && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_primed <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
            if (ctl.ld2) begin
                r_primed <= 1'b1;
            end
        end
    end

    assign o_in_stall  = !rdy1;
    assign o_out_valid = r_v3;

    // Step selection and change allowances
    vcsl_step u_step (
        .i_clk          (i_clk),
        .i_ctl          (ctl),
        .i_step_time    (i_in_data.step_time),
        .i_elapsed_time (i_in_data.elapsed_time),
        .i_accel        (r_accel),
        .i_decel        (r_decel),
        .i_ang_accel    (r_ang_accel),
        .o_chg          (chg)
    );

    // Axis lanes
    vcsl_lane u_lane_x (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_target    (i_in_data.target_x),
        .i_limit     (r_limit_x),
        .i_dead_zone (r_dead_zone),
        .i_chg_rise  (chg.rise_lin),
        .i_chg_fall  (chg.fall_lin),
        .o_res       (res_x)
    );

    vcsl_lane u_lane_y (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_target    (i_in_data.target_y),
        .i_limit     (r_limit_y),
        .i_dead_zone (r_dead_zone),
        .i_chg_rise  (chg.rise_lin),
        .i_chg_fall  (chg.fall_lin),
        .o_res       (res_y)
    );

    vcsl_lane u_lane_yaw (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_target    (i_in_data.target_yaw),
        .i_limit     (r_limit_yaw),
        .i_dead_zone (r_dead_zone),
        .i_chg_rise  (chg.ang),
        .i_chg_fall  (chg.ang),
        .o_res       (res_yaw)
    );

    // Flags and output register
    vcsl_merge u_merge (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_res_x     (res_x),
        .i_res_y     (res_y),
        .i_res_yaw   (res_yaw),
        .i_limit_x   (r_limit_x),
        .i_limit_y   (r_limit_y),
        .i_limit_yaw (r_limit_yaw),
        .o_item      (o_out_data)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/vcsl_checker.sv
// Port-level checker for the velocity command slew limiter, bound to the top.
// Depends on vcsl_pkg and velocity_command_slew_limiter_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "velocity_command_slew_limiter_defines.svh"

module vcsl_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        o_in_stall,
    input  wire logic                        o_out_valid,
    input  wire logic                        i_out_stall,
    input  wire vcsl_pkg::t_out_item         o_out_data
);

    logic [2:0] r_inflight;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // Requests accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 3'(in_acc) - 3'(out_acc);
        end
    end

    // Stalled result holds
    `VCSL_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "result changed while stalled")
    // No result without a pending request
    `VCSL_ASSERT(a_no_phantom, !o_out_valid || (r_inflight != 3'd0), "result without request")
    // Never more requests pending than pipeline stages
    `VCSL_ASSERT(a_depth, r_inflight <= 3'd3, "more requests in flight than stages")
    // An empty block takes input
    `VCSL_ASSERT(a_empty_ready, (r_inflight != 3'd0) || !o_in_stall, "stall while empty")

endmodule

bind velocity_command_slew_limiter vcsl_checker u_vcsl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for velocity_command_slew_limiter.
// It drives a directed table and then random commands, and checks every result.
// Depends on vcsl_pkg and the velocity_command_slew_limiter RTL.
`timescale 1ns / 1ps

module tb;

    localparam int REG_COUNT   = 7;
    localparam int CMD_ROWS    = 15;
    localparam int RAND_PHASES = 9;
    localparam int PHASE_ITEMS = 122;
    localparam int LONG_HOLD   = 60;
    localparam int MAX_REPORTS = 10;

    // Register sets used by the directed table
    typedef enum logic [2:0] {
        SET_NONE,
        SET_PASS,
        SET_MAX,
        SET_DEAD,
        SET_ZERO
    } t_reg_set;

    typedef struct packed {
        t_reg_set            reg_set;     // registers loaded before this request
        logic                fixed_want;  // expected result typed in below
        vcsl_pkg::t_in_item  req;
        vcsl_pkg::t_out_item want;
    } t_cmd_row;

    // Order: limit x, limit y, limit yaw, accel, decel, yaw accel, dead zone
    localparam logic [15:0] REG_SETS [5][REG_COUNT] = '{
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd20000, 16'd30000, 16'd32767, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd32767, 16'd32767, 16'd32767, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0},
        // top bit of the 15-bit limit is dropped, leaving 500
        '{16'h81F4, 16'd32767, 16'd0, 16'd1000, 16'd40000, 16'hFFFF, 16'd1000},
        '{16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd20, 16'd300, 16'hFFFF}
    };

    localparam t_cmd_row CMD_TABLE [CMD_ROWS] = '{
        // first request after reset is taken as it is
        '{SET_PASS, 1'b1, '{16'sd15000, -16'sd25000, 16'sh7FFF, 16'd1000, 16'd0},
          '{16'sd15000, -16'sd25000, 16'sh7FFF, 1'b1 ^ 1'b1, 1'b0, 1'b1, 1'b1}},
        // zero acceleration: held speeds stay, every axis is clamped
        '{SET_NONE, 1'b1, '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'd30, 16'd0},
          '{16'sd15000, -16'sd25000, 16'sh7FFF, 1'b1, 1'b1, 1'b1, 1'b1}},
        // full rates, longest step, most negative command
        '{SET_MAX, 1'b0, '{16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF, 16'hFFFF}, '0},
        '{SET_NONE, 1'b0, '{16'sh8000, 16'sh8000, 16'sh8000, 16'd0, 16'd0}, '0},
        '{SET_NONE, 1'b0, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'd6554, 16'd6554}, '0},
        '{SET_NONE, 1'b0, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'd0}, '0},
        '{SET_NONE, 1'b0, '{16'sd0, 16'sd0, 16'sd0, 16'd3277, 16'd3277}, '0},
        '{SET_NONE, 1'b0, '{16'sd0, 16'sd0, 16'sd0, 16'd3277, 16'd3278}, '0},
        // dead zone edges, zero yaw limit
        '{SET_DEAD, 1'b0, '{16'sd999, -16'sd999, 16'sd100, 16'd6555, 16'd0}, '0},
        '{SET_NONE, 1'b0, '{16'sd1000, -16'sd1000, -16'sd1, 16'd65, 16'd66}, '0},
        '{SET_NONE, 1'b0, '{-16'sd1001, 16'sd501, 16'sh7FFF, 16'd3276, 16'd3276}, '0},
        '{SET_NONE, 1'b0, '{-16'sd1001, 16'sd501, 16'sh7FFF, 16'd3276, 16'd3276}, '0},
        // all limits zero, full dead zone
        '{SET_ZERO, 1'b0, '{16'sd12345, -16'sd12345, 16'sd7, 16'd100, 16'd100}, '0},
        '{SET_NONE, 1'b0, '{16'sh5555, 16'shAAAA, 16'sd0, 16'h5555, 16'hAAAA}, '0},
        '{SET_NONE, 1'b0, '{16'shAAAA, 16'sh5555, 16'sh8000, 16'hAAAA, 16'h5555}, '0}
    };

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [vcsl_pkg::CFG_AW-1:0]     cfg_addr  = '0;
    logic [vcsl_pkg::CFG_DW-1:0]     cfg_wdata = '0;
    logic                            in_valid  = 1'b0;
    vcsl_pkg::t_in_item              in_data   = '0;
    logic                            out_stall = 1'b0;
    logic                            in_stall;
    logic                            out_valid;
    vcsl_pkg::t_out_item             out_data;

    // Register copies and held speeds of the predictor
    int lim_x, lim_y, lim_yaw, acc_up, acc_down, acc_yaw, dead_band;
    int cur_vx, cur_vy, cur_wz;
    bit first_done;

    logic [15:0]         next_regs [REG_COUNT];
    vcsl_pkg::t_out_item speeds_due [$];

    bit send_gaps, recv_gaps, long_hold;
    int fault_count, results_checked, slewed_seen, clamped_seen;
    int cmds_sent, reg_loads, in_stall_cycles;

    always #2 clk = ~clk;

    velocity_command_slew_limiter DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    function automatic int magnitude(input int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int dead_banded(input logic signed [15:0] cmd);
        int v;
        v = cmd;
        return magnitude(v) < dead_band ? 0 : v;
    endfunction

    function automatic int clip(input int v, input int lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic int slew_toward(input int tgt, input int cur, input int step,
                                       input int up, input int down);
        int diff, chg;
        diff = tgt - cur;
        if (diff == 0) return tgt;
        chg = ((diff > 0 ? up : down) * step) >>> 16;
        if (magnitude(diff) <= chg) return tgt;
        return diff > 0 ? cur + chg : cur - chg;
    endfunction

    // Next shaped speeds for one command; advances the held speeds
    function automatic vcsl_pkg::t_out_item shape_velocity(input vcsl_pkg::t_in_item r);
        vcsl_pkg::t_out_item res;
        int dx, dy, dz, tx, ty, tz, step;
        dx = dead_banded(r.target_x);
        dy = dead_banded(r.target_y);
        dz = dead_banded(r.target_yaw);
        tx = clip(dx, lim_x);
        ty = clip(dy, lim_y);
        tz = clip(dz, lim_yaw);
        step = r.step_time;
        if (step < int'(vcsl_pkg::STEP_MIN)) step = vcsl_pkg::STEP_MIN;
        if (step > int'(vcsl_pkg::STEP_MAX)) step = vcsl_pkg::STEP_MAX;
        if (int'(r.elapsed_time) > step) step = r.elapsed_time;
        if (step > int'(vcsl_pkg::STEP_CAP)) step = vcsl_pkg::STEP_CAP;
        res.was_slewed = 1'b0;
        if (!first_done) begin
            cur_vx = tx;
            cur_vy = ty;
            cur_wz = tz;
            first_done = 1'b1;
        end else begin
            cur_vx = slew_toward(tx, cur_vx, step, acc_up, acc_down);
            cur_vy = slew_toward(ty, cur_vy, step, acc_up, acc_down);
            cur_wz = slew_toward(tz, cur_wz, step, acc_yaw, acc_yaw);
            res.was_slewed = cur_vx != tx || cur_vy != ty || cur_wz != tz;
        end
        res.speed_x     = 16'(cur_vx);
        res.speed_y     = 16'(cur_vy);
        res.speed_yaw   = 16'(cur_wz);
        res.was_clamped = tx != dx || ty != dy || tz != dz;
        res.is_moving   = magnitude(cur_vx) > int'(vcsl_pkg::MOVE_LIN) ||
                          magnitude(cur_vy) > int'(vcsl_pkg::MOVE_LIN) ||
                          magnitude(cur_wz) > int'(vcsl_pkg::MOVE_ANG);
        res.at_max      = 20 * magnitude(cur_vx) >= 19 * lim_x ||
                          20 * magnitude(cur_vy) >= 19 * lim_y ||
                          20 * magnitude(cur_wz) >= 19 * lim_yaw;
        return res;
    endfunction

    function automatic void note_reg(input vcsl_pkg::t_cfg_idx idx, input logic [15:0] v);
        case (idx)
            vcsl_pkg::CFG_LIMIT_X:   lim_x     = v[14:0];
            vcsl_pkg::CFG_LIMIT_Y:   lim_y     = v[14:0];
            vcsl_pkg::CFG_LIMIT_YAW: lim_yaw   = v[14:0];
            vcsl_pkg::CFG_ACCEL:     acc_up    = v;
            vcsl_pkg::CFG_DECEL:     acc_down  = v;
            vcsl_pkg::CFG_ANG_ACCEL: acc_yaw   = v;
            vcsl_pkg::CFG_DEAD_ZONE: dead_band = v[14:0];
            default: ;
        endcase
    endfunction

    function automatic void flag_fault(input string msg);
        if (fault_count < MAX_REPORTS) $display("%0t: %s", $realtime, msg);
        fault_count++;
    endfunction

    // Random command speed, mostly around the current limit and dead zone
    function automatic logic signed [15:0] pick_speed(input int lim);
        int span, v;
        span = lim + lim / 8 + 1;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 1) ? 32767 : -32768;
            1: v = $signed(16'($urandom));
            2: v = int'($urandom_range(0, 2 * (dead_band + 3))) - (dead_band + 3);
            default: v = int'($urandom_range(0, 2 * span)) - span;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    function automatic logic [15:0] pick_time();
        case ($urandom_range(0, 6))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 80));
            2: return 16'($urandom_range(3260, 3290));
            3: return 16'($urandom_range(6540, 6570));
            default: return 16'($urandom_range(60, 3000));
        endcase
    endfunction

    function automatic logic [15:0] pick_reg(input vcsl_pkg::t_cfg_idx idx);
        if (idx == vcsl_pkg::CFG_DEAD_ZONE && $urandom_range(0, 3) != 0)
            return {1'($urandom), 15'($urandom_range(0, 300))};
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            3: return 16'($urandom_range(0, 3000));
            default: return 16'($urandom_range(2000, 32767));
        endcase
    endfunction

    // Write next_regs into every register, one per clock
    task automatic load_regs();
        for (int i = 0; i < REG_COUNT; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= vcsl_pkg::t_cfg_idx'(i);
            cfg_wdata <= next_regs[i];
            note_reg(vcsl_pkg::t_cfg_idx'(i), next_regs[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        reg_loads++;
    endtask

    // Offer one request and hold it until taken; the expectation is queued on accept
    task automatic send_cmd(input vcsl_pkg::t_in_item r, input bit fixed_want,
                            input vcsl_pkg::t_out_item want);
        vcsl_pkg::t_out_item pred;
        if (send_gaps && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge clk); while (in_stall !== 1'b0);
        pred = shape_velocity(r);
        speeds_due.push_back(fixed_want ? want : pred);
        cmds_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (speeds_due.size() != 0);
    endtask

    // Result checker and output stall pattern
    initial begin
        int stall_left;
        vcsl_pkg::t_out_item want;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && in_valid && in_stall) in_stall_cycles++;
            if (rst_n && $isunknown(out_valid)) flag_fault("result valid unknown");
            if (rst_n && out_valid === 1'b1 && !out_stall) begin
                if (speeds_due.size() == 0) begin
                    flag_fault("result with nothing expected");
                end else begin
                    want = speeds_due.pop_front();
                    results_checked++;
                    slewed_seen  += want.was_slewed;
                    clamped_seen += want.was_clamped;
                    if (out_data.speed_x !== want.speed_x ||
                        out_data.speed_y !== want.speed_y ||
                        out_data.speed_yaw !== want.speed_yaw ||
                        out_data.was_clamped !== want.was_clamped ||
                        out_data.was_slewed !== want.was_slewed ||
                        out_data.is_moving !== want.is_moving ||
                        out_data.at_max !== want.at_max)
                        flag_fault($sformatf(
                            "result %0d: want %0d %0d %0d c%b s%b m%b a%b, got %0d %0d %0d c%b s%b m%b a%b",
                            results_checked, want.speed_x, want.speed_y, want.speed_yaw,
                            want.was_clamped, want.was_slewed, want.is_moving, want.at_max,
                            out_data.speed_x, out_data.speed_y, out_data.speed_yaw,
                            out_data.was_clamped, out_data.was_slewed, out_data.is_moving,
                            out_data.at_max));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (long_hold) begin
                long_hold  = 1'b0;
                stall_left = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 9);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Stimulus
    initial begin
        vcsl_pkg::t_in_item cmd;
        cmd       = '0;
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < CMD_ROWS; i++) begin
            if (CMD_TABLE[i].reg_set != SET_NONE) begin
                drain_results();
                next_regs = REG_SETS[CMD_TABLE[i].reg_set];
                load_regs();
            end
            send_cmd(CMD_TABLE[i].req, CMD_TABLE[i].fixed_want, CMD_TABLE[i].want);
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain_results();
            for (int r = 0; r < REG_COUNT; r++) begin
                if (ph == 0)
                    next_regs[r] = vcsl_pkg::t_cfg_idx'(r) == vcsl_pkg::CFG_DEAD_ZONE ?
                                   16'h0000 : 16'hFFFF;
                else if (ph == 1)
                    next_regs[r] = vcsl_pkg::t_cfg_idx'(r) == vcsl_pkg::CFG_DEAD_ZONE ?
                                   16'hFFFF : 16'h0000;
                else
                    next_regs[r] = pick_reg(vcsl_pkg::t_cfg_idx'(r));
            end
            load_regs();
            send_gaps = $urandom_range(0, 3) != 0;
            recv_gaps = $urandom_range(0, 3) != 0;
            // back-pressure: output held off while requests keep coming
            if (ph == 2) begin
                send_gaps = 1'b0;
                long_hold = 1'b1;
            end
            if (ph == RAND_PHASES - 1) begin
                send_gaps = 1'b0;
                recv_gaps = 1'b0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 4 && n == PHASE_ITEMS / 2) drain_results();
                // targets often repeat so the held speeds can settle
                if (n == 0 || $urandom_range(0, 2) == 0) begin
                    cmd.target_x   = pick_speed(lim_x);
                    cmd.target_y   = pick_speed(lim_y);
                    cmd.target_yaw = pick_speed(lim_yaw);
                end
                cmd.step_time    = pick_time();
                cmd.elapsed_time = pick_time();
                send_cmd(cmd, 1'b0, '0);
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        fault_count += speeds_due.size();
        $display("Sent %0d commands over %0d register loads; %0d results checked.",
                 cmds_sent, reg_loads, results_checked);
        $display("Results slewed %0d, clamped %0d; input held off %0d cycles.",
                 slewed_seen, clamped_seen, in_stall_cycles);
        if (fault_count == 0)
            $display("velocity_command_slew_limiter regression: pass");
        else
            $display("velocity_command_slew_limiter regression: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("velocity_command_slew_limiter regression: fail");
        $finish;
    end

endmodule
